// File: sv/dequ_pkg.sv
// Shared types and codes of the double-ended queue unit.
// No dependencies; compile first.
package dequ_pkg;

    localparam int WORD_W      = 32;
    localparam int COUNT_OUT_W = 7;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_POP_EMPTY = 2'd1,
        STAT_PUSH_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_mode mode;
        t_word value;
    } t_cmd;

    typedef struct packed {
        t_word                  popped_value;
        t_word                  front_value;
        t_word                  back_value;
        logic [COUNT_OUT_W-1:0] count;
        logic                   empty_res;
        t_status                status;
    } t_res;

endpackage

// File: sv/dequ_stream_if.sv
// Valid/ready stream channel carrying one payload of type T per transfer.
// No dependencies; the payload type is supplied by the instantiating code.
interface dequ_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/dequ_store.sv
// Ring word store: one write port, one registered read port with write bypass.
// Depends on dequ_pkg.
module dequ_store import dequ_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0] i_wr_addr,
    input  t_word                       i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(CAPACITY)-1:0] i_rd_addr,
    output t_word                       o_rd_data
);

    t_word mem [CAPACITY];
    t_word r_rd_data;
    t_word r_byp_data;
    logic  r_byp_sel;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // Read of the address written in the same cycle takes the new word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_sel <= 1'b0;
        end else if (i_rd_en) begin
            r_byp_sel <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp_sel ? r_byp_data : r_rd_data;

endmodule

// File: sv/dequ_ctrl.sv
// Queue state (front/back indices, count, cached end words) and per-item update.
// Depends on dequ_pkg.
module dequ_ctrl import dequ_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  t_cmd                        i_cmd,
    input  t_word                       i_rd_data,
    input  t_mode                       i_next_mode,
    output logic                        o_wr_en,
    output logic [$clog2(CAPACITY)-1:0] o_wr_addr,
    output t_word                       o_wr_data,
    output logic [$clog2(CAPACITY)-1:0] o_rd_addr,
    output t_res                        o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [AW-1:0] r_front_idx, n_front_idx;
    logic [AW-1:0] r_back_idx,  n_back_idx;
    logic [CW-1:0] r_count,     n_count;
    t_word         r_front_w,   n_front_w;
    t_word         r_back_w,    n_back_w;

    logic          full, empty, wr_en;
    t_word         popped;
    t_status       status;
    logic [AW-1:0] front_dec, back_inc;
    logic [AW-1:0] s_front_idx, s_back_idx;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] idx);
        return (idx == AW'(CAPACITY - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] idx);
        return (idx == '0) ? AW'(CAPACITY - 1) : idx - 1'b1;
    endfunction

    assign full      = (r_count == CW'(CAPACITY));
    assign empty     = (r_count == '0);
    assign front_dec = f_dec(r_front_idx);
    assign back_inc  = f_inc(r_back_idx);

    always_comb begin
        n_front_idx = r_front_idx;
        n_back_idx  = r_back_idx;
        n_count     = r_count;
        n_front_w   = r_front_w;
        n_back_w    = r_back_w;
        popped      = '0;
        status      = STAT_OK;
        wr_en       = 1'b0;
        o_wr_addr   = front_dec;
        unique case (i_cmd.mode)
            MODE_PUSH_FRONT: begin
                if (full) begin
                    status = STAT_PUSH_FULL;
                end else begin
                    n_front_idx = front_dec;
                    n_count     = r_count + 1'b1;
                    n_front_w   = i_cmd.value;
                    if (empty) begin
                        n_back_w = i_cmd.value;
                    end
                    wr_en     = 1'b1;
                    o_wr_addr = front_dec;
                end
            end
            MODE_PUSH_BACK: begin
                if (full) begin
                    status = STAT_PUSH_FULL;
                end else begin
                    n_back_idx = back_inc;
                    n_count    = r_count + 1'b1;
                    n_back_w   = i_cmd.value;
                    if (empty) begin
                        n_front_w = i_cmd.value;
                    end
                    wr_en     = 1'b1;
                    o_wr_addr = back_inc;
                end
            end
            MODE_POP_FRONT: begin
                if (empty) begin
                    status = STAT_POP_EMPTY;
                end else begin
                    popped      = r_front_w;
                    n_front_idx = f_inc(r_front_idx);
                    n_count     = r_count - 1'b1;
                    n_front_w   = i_rd_data;
                end
            end
            MODE_POP_BACK: begin
                if (empty) begin
                    status = STAT_POP_EMPTY;
                end else begin
                    popped     = r_back_w;
                    n_back_idx = f_dec(r_back_idx);
                    n_count    = r_count - 1'b1;
                    n_back_w   = i_rd_data;
                end
            end
        endcase
    end

    assign o_wr_en   = wr_en && i_fire;
    assign o_wr_data = i_cmd.value;

    // Prefetch the word that becomes the new end if the incoming item pops.
    assign s_front_idx = i_fire ? n_front_idx : r_front_idx;
    assign s_back_idx  = i_fire ? n_back_idx  : r_back_idx;
    assign o_rd_addr   = (i_next_mode == MODE_POP_BACK) ? f_dec(s_back_idx)
                                                        : f_inc(s_front_idx);

    always_comb begin
        o_res.popped_value = popped;
        o_res.front_value  = (n_count == '0) ? '0 : n_front_w;
        o_res.back_value   = (n_count == '0) ? '0 : n_back_w;
        o_res.count        = COUNT_OUT_W'(n_count);
        o_res.empty_res    = (n_count == '0);
        o_res.status       = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_idx <= '0;
            r_back_idx  <= AW'(CAPACITY - 1);
            r_count     <= '0;
        end else if (i_fire) begin
            r_front_idx <= n_front_idx;
            r_back_idx  <= n_back_idx;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_front_w <= n_front_w;
            r_back_w  <= n_back_w;
        end
    end

endmodule

// File: sv/double_ended_queue_unit.sv
// Top level of the double-ended queue unit.
// Depends on dequ_pkg, dequ_stream_if, dequ_store and dequ_ctrl.
//
// A bounded double-ended queue of CAPACITY signed 32-bit words held in a
// ring store. Each command transfer pushes a word at the front or back or
// pops one from either end, and yields exactly one result transfer with the
// popped word, the front and back words afterwards, the count, an empty flag
// and a status (ok, pop on empty ignored, push when full dropped). The unit
// takes one command per cycle for as long as results are taken; a command
// passes through the input register and then the result register. The input
// register serves the store's registered read port, which fetches the next
// end word while the command waits there. The front and back words live in
// registers, so each command needs only that one read. No clearing pass is
// needed after reset.
module double_ended_queue_unit import dequ_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dequ_stream_if.sink         i_cmd,
    dequ_stream_if.source       o_res
);

    localparam int AW = $clog2(CAPACITY);

    // Input register and result register.
    logic   r_in_vld;
    t_cmd   r_in;
    logic   r_out_vld;
    t_res   r_out;

    logic   fire, accept;
    logic   wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_word  wr_data, rd_data;
    t_res   res;

    // Advance the held command when the result register is free or draining.
    assign fire         = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_cmd.ready  = !r_in_vld || fire;
    assign accept       = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_cmd.data;
        end
    end

    // The store read issued on the command transfer lines up with r_in.
    dequ_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    dequ_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_cmd       (r_in),
        .i_rd_data   (rd_data),
        .i_next_mode (i_cmd.data.mode),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .o_res       (res)
    );

    // Hold the result until its transfer; load a new one as the old leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

endmodule

// File: verif/dequ_checker.sv
// Scoreboard for the double-ended queue unit: keeps its own copy of the ring
// store, predicts each result and compares the result transfers with it.
// Depends on dequ_pkg.
module dequ_checker import dequ_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  logic i_cmd_ready,
    input  t_cmd i_cmd_data,
    input  logic i_res_valid,
    input  logic i_res_ready,
    input  t_res i_res_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_refusals,
    output int   o_empty_refusals
);

    t_word       ring_words [CAPACITY];
    int unsigned head_idx;
    int unsigned depth;
    t_res        awaited_q [$];

    // Advance the mirrored queue by one command and return the result it yields.
    function automatic t_res apply_command(input t_cmd c);
        t_res r;
        r = '0;
        r.status = STAT_OK;
        case (c.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (depth >= CAPACITY) begin
                    r.status = STAT_PUSH_FULL;
                end else if (c.mode == MODE_PUSH_FRONT) begin
                    head_idx = (head_idx == 0) ? CAPACITY - 1 : head_idx - 1;
                    ring_words[head_idx] = c.value;
                    depth++;
                end else begin
                    ring_words[(head_idx + depth) % CAPACITY] = c.value;
                    depth++;
                end
            end
            default: begin
                if (depth == 0) begin
                    r.status = STAT_POP_EMPTY;
                end else if (c.mode == MODE_POP_FRONT) begin
                    r.popped_value = ring_words[head_idx];
                    head_idx = (head_idx + 1) % CAPACITY;
                    depth--;
                end else begin
                    r.popped_value = ring_words[(head_idx + depth - 1) % CAPACITY];
                    depth--;
                end
            end
        endcase
        if (depth != 0) begin
            r.front_value = ring_words[head_idx];
            r.back_value  = ring_words[(head_idx + depth - 1) % CAPACITY];
        end
        r.count     = COUNT_OUT_W'(depth);
        r.empty_res = (depth == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            head_idx = 0;
            depth    = 0;
            awaited_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (awaited_q.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    o_fail_count++;
                end else begin
                    want = awaited_q.pop_front();
                    check_field("popped_value", want.popped_value, i_res_data.popped_value);
                    check_field("front_value", want.front_value, i_res_data.front_value);
                    check_field("back_value", want.back_value, i_res_data.back_value);
                    check_field("count", 32'(want.count), 32'(i_res_data.count));
                    check_field("empty_res", 32'(want.empty_res), 32'(i_res_data.empty_res));
                    check_field("status", 32'(want.status), 32'(i_res_data.status));
                    o_checked++;
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                want = apply_command(i_cmd_data);
                awaited_q.push_back(want);
                if (want.status == STAT_PUSH_FULL)
                    o_full_refusals++;
                if (want.status == STAT_POP_EMPTY)
                    o_empty_refusals++;
            end
        end
        o_pending = awaited_q.size();
    end

endmodule

// File: verif/tb.sv
// Testbench top for the double-ended queue unit: drives commands, paces the
// result channel and gives the verdict from the checker's failure count.
// Depends on dequ_pkg, dequ_stream_if, double_ended_queue_unit, dequ_checker.
module tb;
    import dequ_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int RANDOM_CMDS = 750;
    localparam int CYCLE_LIMIT = 200_000;

    logic i_clk;
    logic i_rst_n;

    dequ_stream_if #(.T(t_cmd)) cmd_if ();
    dequ_stream_if #(.T(t_res)) res_if ();

    int fail_count;
    int pending;
    int checked;
    int full_refusals;
    int empty_refusals;

    int sent_count = 0;
    int burst_left = 0;
    int cycle_count = 0;
    int stall_style = 0;
    int stall_span = 0;

    double_ended_queue_unit #(.CAPACITY(CAPACITY)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    // The checker only watches: it samples both channels at the same edges as the unit.
    dequ_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd_if.valid),
        .i_cmd_ready      (cmd_if.ready),
        .i_cmd_data       (cmd_if.data),
        .i_res_valid      (res_if.valid),
        .i_res_ready      (res_if.ready),
        .i_res_data       (res_if.data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_full_refusals  (full_refusals),
        .o_empty_refusals (empty_refusals)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung handshake: abandon the run well past the slowest legal finish.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: hold one stall style for a random span, then pick another.
    // Styles are always ready, mostly ready and mostly stalled. This block is
    // the only driver of the result ready; it starts at the first edge, while
    // the unit is still held in reset.
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_style <= $urandom_range(0, 2);
            stall_span  <= $urandom_range(40, 250);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_style)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= ($urandom_range(0, 9) < 7);
            default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Mostly fully random words, with the corner values mixed in now and then.
    function automatic t_word pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return t_word'($urandom());
        endcase
    endfunction

    // Present one command and hold it until the transfer. At the end of a burst
    // drop valid and idle for a random gap; otherwise keep valid high so the next
    // command follows back to back.
    task automatic send_cmd(input t_mode m, input t_word v);
        t_cmd c;
        c.mode  = m;
        c.value = v;
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sent_count++;
        burst_left--;
        if (burst_left <= 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    initial begin
        t_mode m;
        int    push_pct;
        int    phase_len;
        int    phase_idx;
        int    random_sent;
        int    fill_pct [3];
        fill_pct    = '{90, 50, 10};
        random_sent = 0;
        phase_idx   = 0;

        // Drive reset and the command channel to known values before the first edge.
        i_rst_n      <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 12);

        // Directed: pops on an empty queue, corner words at both ends, pops in
        // either order back down to empty, and alternating bit patterns.
        send_cmd(MODE_POP_FRONT, 32'sh1234_5678);
        send_cmd(MODE_POP_BACK, -32'sd1);
        send_cmd(MODE_PUSH_FRONT, 32'sh8000_0000);
        send_cmd(MODE_PUSH_BACK, 32'sh7fff_ffff);
        send_cmd(MODE_PUSH_FRONT, '0);
        send_cmd(MODE_PUSH_BACK, -32'sd1);
        send_cmd(MODE_POP_FRONT, '0);
        send_cmd(MODE_POP_BACK, '0);
        send_cmd(MODE_POP_BACK, '0);
        send_cmd(MODE_POP_FRONT, '0);
        send_cmd(MODE_POP_BACK, 32'sh7fff_ffff);
        send_cmd(MODE_PUSH_BACK, 32'shaaaa_aaaa);
        send_cmd(MODE_POP_FRONT, '0);
        send_cmd(MODE_PUSH_FRONT, 32'sh5555_5555);
        send_cmd(MODE_POP_BACK, '0);
        send_cmd(MODE_PUSH_FRONT, 32'sd1);
        send_cmd(MODE_PUSH_BACK, 32'sd2);
        send_cmd(MODE_POP_FRONT, '0);
        send_cmd(MODE_POP_FRONT, '0);
        send_cmd(MODE_POP_FRONT, '0);

        // Random: phases biased towards filling, mixing and draining, so the
        // queue runs into full and empty repeatedly and the ring wraps. The
        // opening phase pushes only, which guarantees pushes onto a full queue.
        push_pct  = 100;
        phase_len = 70;
        while (random_sent < RANDOM_CMDS) begin
            for (int k = 0; k < phase_len && random_sent < RANDOM_CMDS; k++) begin
                if ($urandom_range(0, 99) < push_pct)
                    m = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
                else
                    m = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
                send_cmd(m, pick_word());
                random_sent++;
            end
            push_pct  = fill_pct[phase_idx];
            phase_idx = (phase_idx + 1) % 3;
            phase_len = $urandom_range(60, 140);
        end
        if (burst_left > 0)
            cmd_if.valid <= 1'b0;

        // Drain: wait for every outstanding result, then idle on to catch any stray
        // transfer.
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d commands and %0d checked results.", sent_count, checked);
        $display("Pushes refused when full: %0d; pops refused when empty: %0d.",
                 full_refusals, empty_refusals);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
